// ===== hdl/undirected_graph_cycle_detect_top_macros.svh =====
// Assertion macros for the undirected graph cycle detector.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef UNDIRECTED_GRAPH_CYCLE_DETECT_TOP_MACROS_SVH
`define UNDIRECTED_GRAPH_CYCLE_DETECT_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UGCD_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UGCD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ugcd_pkg.sv =====
// Package for the undirected graph cycle detector.
// Holds the command and status structs shared by controller and datapath.
package ugcd_pkg;

   localparam int unsigned END_W = 7;
   localparam int unsigned VC_W  = 8;

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   typedef struct packed {
      logic capture;
      logic add_err;
      logic add_wa;
      logic add_wb;
      logic ev_init;
      logic scan_next;
      logic start_push;
      logic load_top;
      logic pop;
      logic pop_load;
      logic edge_update;
      logic mark_w;
      logic push;
      logic set_cyc;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic edge_ok;
      logic scan_end;
      logic start_seen;
      logic top_cv;
      logic sp_last;
      logic w_seen;
      logic stack_full;
      logic w_parent;
      logic rsp_busy;
   } sts_type;

endpackage

// ===== hdl/ugcd_if.sv =====
// Channel interfaces of the cycle detector: request and response beats.
// Depends on ugcd_pkg for the endpoint width.
interface ugcd_req_if;
   logic                             valid;
   logic                             ready;
   logic                             command;
   logic [ugcd_pkg::END_W-1:0]       end_a;
   logic [ugcd_pkg::END_W-1:0]       end_b;

   modport source (output valid, command, end_a, end_b, input ready);
   modport sink   (input valid, command, end_a, end_b, output ready);
endinterface

interface ugcd_rsp_if;
   logic valid;
   logic ready;
   logic has_cycle;
   logic edge_error;

   modport source (output valid, has_cycle, edge_error, input ready);
   modport sink   (input valid, has_cycle, edge_error, output ready);
endinterface

// ===== hdl/ugcd_ctrl.sv =====
// Controller state machine of the cycle detector.
// Depends on ugcd_pkg; drives datapath commands from datapath status.
module ugcd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_command,
   output logic              req_ready,
   input  ugcd_pkg::sts_type sts,
   output ugcd_pkg::cmd_type cmd
);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_ADD_RD = 10'b00_0000_0010,
      ST_ADD_WA = 10'b00_0000_0100,
      ST_ADD_WB = 10'b00_0000_1000,
      ST_SCAN   = 10'b00_0001_0000,
      ST_HEAD   = 10'b00_0010_0000,
      ST_STEP   = 10'b00_0100_0000,
      ST_POP    = 10'b00_1000_0000,
      ST_EDGE   = 10'b01_0000_0000,
      ST_DONE   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_command == ugcd_pkg::CMD_EVAL) begin
                  cmd.ev_init = 1'b1;
                  state_in    = ST_SCAN;
               end else begin
                  state_in = ST_ADD_RD;
               end
            end
         end
         ST_ADD_RD: begin
            if (sts.edge_ok) begin
               state_in = ST_ADD_WA;
            end else begin
               cmd.add_err = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_ADD_WA: begin
            cmd.add_wa = 1'b1;
            state_in   = ST_ADD_WB;
         end
         ST_ADD_WB: begin
            cmd.add_wb = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_SCAN: begin
            priority if (sts.scan_end) begin
               state_in = ST_DONE;
            end else if (sts.start_seen) begin
               cmd.scan_next = 1'b1;
            end else begin
               cmd.start_push = 1'b1;
               state_in       = ST_HEAD;
            end
         end
         ST_HEAD: begin
            cmd.load_top = 1'b1;
            state_in     = ST_STEP;
         end
         ST_STEP: begin
            priority if (sts.top_cv) begin
               state_in = ST_EDGE;
            end else if (sts.sp_last) begin
               cmd.scan_next = 1'b1;
               state_in      = ST_SCAN;
            end else begin
               cmd.pop  = 1'b1;
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            cmd.pop_load = 1'b1;
            state_in     = ST_STEP;
         end
         ST_EDGE: begin
            cmd.edge_update = 1'b1;
            priority if (!sts.w_seen) begin
               cmd.mark_w = 1'b1;
               if (sts.stack_full) begin
                  state_in = ST_STEP;
               end else begin
                  cmd.push = 1'b1;
                  state_in = ST_HEAD;
               end
            end else if (!sts.w_parent) begin
               cmd.set_cyc = 1'b1;
               state_in    = ST_DONE;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/ugcd_dp.sv =====
// Datapath of the cycle detector: list heads, half-edge store, search stack,
// visited flags and the response register. Depends on ugcd_pkg.
module ugcd_dp #(
   parameter int unsigned MaxVertices = 128,
   parameter int unsigned MaxEdges    = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ugcd_pkg::cmd_type               cmd,
   output ugcd_pkg::sts_type               sts,
   input  logic [ugcd_pkg::END_W-1:0]      end_a,
   input  logic [ugcd_pkg::END_W-1:0]      end_b,
   input  logic                            csr_wr_en,
   input  logic [ugcd_pkg::VC_W-1:0]       csr_wr_data,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic                            has_cycle,
   output logic                            edge_error
);

   localparam int unsigned VW   = $clog2(MaxVertices);
   localparam int unsigned NW   = $clog2(MaxVertices + 1);
   localparam int unsigned HALF = 2 * MaxEdges;
   localparam int unsigned HW   = $clog2(HALF);
   localparam int unsigned EW   = $clog2(MaxEdges + 1);
   localparam int unsigned CW   = NW + ugcd_pkg::VC_W;
   localparam int unsigned EV   = 1 + HW + VW;

   typedef struct packed {
      logic [VW-1:0] vertex;
      logic [VW-1:0] parent;
      logic          hp;
      logic [HW-1:0] cursor;
      logic          cv;
   } frame_type;

   // Memories
   logic [HW-1:0] head_mem [MaxVertices];
   logic [EV-1:0] he_mem   [HALF];
   frame_type     stk_mem  [MaxVertices];

   logic [HW-1:0] head_q0, head_q1;
   logic [EV-1:0] he_q;
   frame_type     stk_q;

   // Control state
   logic [ugcd_pkg::VC_W-1:0] vc_ff, vc_in;
   logic [EW-1:0]             edge_total_ff, edge_total_in;
   logic                      err_ff, err_in;
   logic                      cyc_ff, cyc_in;
   logic [MaxVertices-1:0]    hv_ff, hv_in;
   logic [MaxVertices-1:0]    visited_ff, visited_in;
   logic [NW-1:0]             sp_ff, sp_in;
   logic [NW-1:0]             start_ff, start_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [ugcd_pkg::END_W-1:0] a_ff, a_in, b_ff, b_in;
   frame_type                  top_ff, top_in;
   logic [VW-1:0]              nv_ff, nv_in, np_ff, np_in;
   logic                       nhp_ff, nhp_in;
   logic                       has_cycle_ff, has_cycle_in;
   logic                       edge_error_ff, edge_error_in;

   logic [CW-1:0] vc_ext, max_ext, n_ext;
   logic [VW-1:0] av, bv, w, start_v;
   logic [HW-1:0] slot0, slot1, link;
   logic          lv;
   logic          head_we;
   logic [VW-1:0] head_wa, head_ra0;
   logic [HW-1:0] head_wd, he_wa;
   logic [EV-1:0] he_wd;
   frame_type     push_frame;

   assign vc_ext  = CW'(vc_ff);
   assign max_ext = CW'(MaxVertices);
   assign n_ext   = (vc_ext > max_ext) ? max_ext : vc_ext;

   assign av      = VW'(a_ff);
   assign bv      = VW'(b_ff);
   assign start_v = VW'(start_ff);
   assign slot0   = HW'({edge_total_ff, 1'b0});
   assign slot1   = HW'({edge_total_ff, 1'b1});

   assign w    = he_q[VW-1:0];
   assign link = he_q[VW +: HW];
   assign lv   = he_q[EV-1];

   assign sts.edge_ok    = (CW'(a_ff) < n_ext) && (CW'(b_ff) < n_ext)
                           && (edge_total_ff < EW'(MaxEdges));
   assign sts.scan_end   = CW'(start_ff) >= n_ext;
   assign sts.start_seen = visited_ff[start_v];
   assign sts.top_cv     = top_ff.cv;
   assign sts.sp_last    = sp_ff == NW'(1);
   assign sts.w_seen     = visited_ff[w];
   assign sts.stack_full = sp_ff >= NW'(MaxVertices);
   assign sts.w_parent   = top_ff.hp && (w == top_ff.parent);
   assign sts.rsp_busy   = rsp_valid_ff && !rsp_ready;

   // Head list port: the first read serves the add path and the search.
   always_comb begin
      head_we = cmd.add_wa | cmd.add_wb;
      head_wa = cmd.add_wa ? av : bv;
      head_wd = cmd.add_wa ? slot0 : slot1;
      he_wa   = cmd.add_wa ? slot0 : slot1;
      priority if (cmd.start_push) begin
         head_ra0 = start_v;
      end else if (cmd.push) begin
         head_ra0 = w;
      end else begin
         head_ra0 = av;
      end
      // For a self-loop the second half-edge links to the first one.
      if (cmd.add_wa) begin
         he_wd = {hv_ff[av], head_q0, bv};
      end else begin
         he_wd = {hv_ff[bv], (a_ff == b_ff) ? slot0 : head_q1, av};
      end
      push_frame        = top_ff;
      push_frame.cursor = link;
      push_frame.cv     = lv;
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      head_q0 <= head_mem[head_ra0];
      head_q1 <= head_mem[bv];
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         he_mem[he_wa] <= he_wd;
      end
      he_q <= he_mem[top_ff.cursor];
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stk_mem[VW'(sp_ff - NW'(1))] <= push_frame;
      end
      stk_q <= stk_mem[VW'(sp_ff - NW'(2))];
   end

   always_comb begin
      vc_in         = csr_wr_en ? csr_wr_data : vc_ff;
      edge_total_in = edge_total_ff;
      err_in        = err_ff;
      cyc_in        = cyc_ff;
      hv_in         = hv_ff;
      visited_in    = visited_ff;
      sp_in         = sp_ff;
      start_in      = start_ff;
      rsp_valid_in  = rsp_valid_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      top_in        = top_ff;
      nv_in         = nv_ff;
      np_in         = np_ff;
      nhp_in        = nhp_ff;
      has_cycle_in  = has_cycle_ff;
      edge_error_in = edge_error_ff;

      if (cmd.capture) begin
         a_in = end_a;
         b_in = end_b;
      end
      if (cmd.add_err) begin
         err_in = 1'b1;
      end
      if (cmd.add_wa) begin
         hv_in[av] = 1'b1;
      end
      if (cmd.add_wb) begin
         hv_in[bv]     = 1'b1;
         edge_total_in = edge_total_ff + EW'(1);
      end
      if (cmd.ev_init) begin
         start_in = '0;
         cyc_in   = 1'b0;
      end
      if (cmd.scan_next) begin
         start_in = start_ff + NW'(1);
      end
      if (cmd.start_push) begin
         visited_in[start_v] = 1'b1;
         nv_in               = start_v;
         np_in               = '0;
         nhp_in              = 1'b0;
         sp_in               = NW'(1);
      end
      if (cmd.load_top) begin
         top_in = '{vertex: nv_ff, parent: np_ff, hp: nhp_ff,
                    cursor: head_q0, cv: hv_ff[nv_ff]};
      end
      if (cmd.pop) begin
         sp_in = sp_ff - NW'(1);
      end
      if (cmd.pop_load) begin
         top_in = stk_q;
      end
      if (cmd.edge_update) begin
         top_in.cursor = link;
         top_in.cv     = lv;
      end
      if (cmd.mark_w) begin
         visited_in[w] = 1'b1;
      end
      if (cmd.push) begin
         sp_in  = sp_ff + NW'(1);
         nv_in  = w;
         np_in  = top_ff.vertex;
         nhp_in = 1'b1;
      end
      if (cmd.set_cyc) begin
         cyc_in = 1'b1;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      // Answering also clears the graph and the sticky error.
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         has_cycle_in  = cyc_ff;
         edge_error_in = err_ff;
         hv_in         = '0;
         visited_in    = '0;
         edge_total_in = '0;
         err_in        = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff         <= ugcd_pkg::VC_W'(128);
         edge_total_ff <= '0;
         err_ff        <= 1'b0;
         cyc_ff        <= 1'b0;
         hv_ff         <= '0;
         visited_ff    <= '0;
         sp_ff         <= '0;
         start_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         vc_ff         <= vc_in;
         edge_total_ff <= edge_total_in;
         err_ff        <= err_in;
         cyc_ff        <= cyc_in;
         hv_ff         <= hv_in;
         visited_ff    <= visited_in;
         sp_ff         <= sp_in;
         start_ff      <= start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      b_ff          <= b_in;
      top_ff        <= top_in;
      nv_ff         <= nv_in;
      np_ff         <= np_in;
      nhp_ff        <= nhp_in;
      has_cycle_ff  <= has_cycle_in;
      edge_error_ff <= edge_error_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign has_cycle  = has_cycle_ff;
   assign edge_error = edge_error_ff;

endmodule

// ===== hdl/undirected_graph_cycle_detect_top.sv =====
// Undirected graph cycle detector. An add beat (command 0) stores edge end_a-end_b as
// two half-edges at the front of the endpoints' adjacency lists. After acceptance the
// block checks the endpoints and reads the list heads, then writes each half-edge in
// turn through the single write port of the half-edge store, then returns to idle to
// take the next beat; a dropped edge goes straight back to idle after the check.
// An evaluate beat (command 1) runs a depth-first search with a stack in memory and
// returns one response beat with has_cycle and edge_error, then clears the graph. Each
// step of the search through the adjacency lists and the stack waits on one registered
// memory read. A finished response is held in an output register, so adds continue
// while it waits. vertex_count may be written only while the block is idle.
`include "undirected_graph_cycle_detect_top_macros.svh"

module undirected_graph_cycle_detect_top #(
   parameter int unsigned MaxVertices = 128,
   parameter int unsigned MaxEdges    = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   ugcd_req_if.sink                       req_chan,
   ugcd_rsp_if.source                     rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [ugcd_pkg::VC_W-1:0]      csr_wr_data
);

   ugcd_pkg::cmd_type cmd;
   ugcd_pkg::sts_type sts;

   ugcd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_chan.ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   ugcd_dp #(
      .MaxVertices (MaxVertices),
      .MaxEdges    (MaxEdges)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .end_a       (req_chan.end_a),
      .end_b       (req_chan.end_b),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .has_cycle   (rsp_chan.has_cycle),
      .edge_error  (rsp_chan.edge_error)
   );

   // An evaluate beat takes the block away from the request side.
   `UGCD_ASSERT_NEXT(a_eval_busy, req_chan.valid && req_chan.ready && req_chan.command == ugcd_pkg::CMD_EVAL, !req_chan.ready, "request accepted during search")
   // A response is loaded only when the output register is free.
   `UGCD_ASSERT_IMPLY(a_rsp_free, cmd.rsp_load, !rsp_chan.valid || rsp_chan.ready, "response overwritten")
   // Loading a response presents it and reopens the request side.
   `UGCD_ASSERT_NEXT(a_rsp_shown, cmd.rsp_load, rsp_chan.valid && req_chan.ready, "response not presented")

endmodule

// ===== test/tb_undirected_graph_cycle_detect_top.sv =====
// Self-checking testbench for the undirected graph cycle detector top level.
// Depends on ugcd_pkg, the ugcd_req_if and ugcd_rsp_if interfaces, and the RTL.
module tb_undirected_graph_cycle_detect_top;

   localparam int unsigned VERT_CAP   = 128;
   localparam int unsigned EDGE_CAP   = 1024;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int unsigned ITEM_TARGET = 1550;

   typedef struct {
      bit has_cycle;
      bit edge_error;
   } cycle_answer_type;

   // Scoreboard: keeps its own copy of the graph and predicts each evaluate.
   class cycle_scoreboard;
      int unsigned      vcount;
      int               list_head[VERT_CAP];
      bit [6:0]         half_target[2*EDGE_CAP];
      int               half_link[2*EDGE_CAP];
      int unsigned      edges_held;
      bit               dropped;
      bit               seen[VERT_CAP];
      cycle_answer_type answers[$];
      int unsigned      fails;
      int unsigned      edges_sent;
      int unsigned      evals_sent;
      int unsigned      cycles_found;

      function new();
         vcount = VERT_CAP;
         fails = 0;
         edges_sent = 0;
         evals_sent = 0;
         cycles_found = 0;
         clear_graph();
      endfunction

      function void clear_graph();
         foreach (list_head[i]) list_head[i] = -1;
         edges_held = 0;
         dropped = 0;
      endfunction

      function void set_count(int unsigned value);
         vcount = value;
      endfunction

      function int unsigned limit_count();
         return (vcount > VERT_CAP) ? VERT_CAP : vcount;
      endfunction

      function void link_half(int slot, int from, bit [6:0] to);
         half_target[slot] = to;
         half_link[slot] = list_head[from];
         list_head[from] = slot;
      endfunction

      function bit search_from(int start);
         int   fv[VERT_CAP];
         int   fp[VERT_CAP];
         bit   fhp[VERT_CAP];
         int   fc[VERT_CAP];
         int   sp;
         int   h;
         int   w;
         seen[start] = 1;
         fv[0] = start;
         fp[0] = 0;
         fhp[0] = 0;
         fc[0] = list_head[start];
         sp = 1;
         while (sp > 0) begin
            if (fc[sp-1] < 0) begin
               sp--;
               continue;
            end
            h = fc[sp-1];
            w = half_target[h];
            fc[sp-1] = half_link[h];
            if (!seen[w]) begin
               seen[w] = 1;
               if (sp >= VERT_CAP) continue;
               fv[sp] = w;
               fp[sp] = fv[sp-1];
               fhp[sp] = 1;
               fc[sp] = list_head[w];
               sp++;
            end else if (!(fhp[sp-1] && w == fp[sp-1])) begin
               return 1;
            end
         end
         return 0;
      endfunction

      function void note_request(bit cmd, bit [6:0] a, bit [6:0] b);
         int unsigned      n;
         cycle_answer_type ans;
         n = limit_count();
         if (cmd == ugcd_pkg::CMD_ADD) begin
            edges_sent++;
            if (a >= n || b >= n || edges_held >= EDGE_CAP) begin
               dropped = 1;
            end else begin
               link_half(2*edges_held, a, b);
               link_half(2*edges_held + 1, b, a);
               edges_held++;
            end
         end else begin
            evals_sent++;
            ans.has_cycle = 0;
            foreach (seen[i]) seen[i] = 0;
            for (int i = 0; i < n; i++) begin
               if (!seen[i] && search_from(i)) begin
                  ans.has_cycle = 1;
                  break;
               end
            end
            ans.edge_error = dropped;
            if (ans.has_cycle) cycles_found++;
            answers.push_back(ans);
            clear_graph();
         end
      endfunction

      task report(string msg);
         $display("MISMATCH: %s", msg);
         fails++;
      endtask

      task check_response(bit has_cycle, bit edge_error);
         cycle_answer_type ans;
         if (answers.size() == 0) begin
            report($sformatf("response beat with nothing expected (%0b,%0b)",
                             has_cycle, edge_error));
            return;
         end
         ans = answers.pop_front();
         if (has_cycle !== ans.has_cycle)
            report($sformatf("has_cycle %0b, expected %0b", has_cycle, ans.has_cycle));
         if (edge_error !== ans.edge_error)
            report($sformatf("edge_error %0b, expected %0b", edge_error, ans.edge_error));
      endtask

      function int unsigned pending();
         return answers.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [ugcd_pkg::VC_W-1:0] csr_wr_data;
   int unsigned cycle_count;
   int unsigned items_sent;
   int unsigned rsp_stall;
   bit quiet;
   cycle_scoreboard sb;

   ugcd_req_if req ();
   ugcd_rsp_if rsp ();

   undirected_graph_cycle_detect_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req),
      .rsp_chan    (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset = 1;
      req.valid = 0;
      req.command = ugcd_pkg::CMD_ADD;
      req.end_a = '0;
      req.end_b = '0;
      rsp.ready = 0;
      csr_wr_en = 0;
      csr_wr_data = '0;
      sb = new();
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver side: random stall bursts unless the run is in its quiet tail.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 0;
         rsp_stall <= 0;
      end else if (rsp_stall > 0) begin
         rsp.ready <= 0;
         rsp_stall <= rsp_stall - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp.ready <= 0;
         rsp_stall <= $urandom_range(0, 2);
      end else begin
         rsp.ready <= 1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) sb.note_request(req.command, req.end_a, req.end_b);
         if (rsp.valid && rsp.ready) sb.check_response(rsp.has_cycle, rsp.edge_error);
      end
   end

   // Presents one beat and returns at the edge where it is taken.
   task automatic send_beat(bit cmd, bit [6:0] a, bit [6:0] b);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req.valid <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req.valid <= 1;
      req.command <= cmd;
      req.end_a <= a;
      req.end_b <= b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic add_edge(int a, int b);
      send_beat(ugcd_pkg::CMD_ADD, a[6:0], b[6:0]);
   endtask

   task automatic evaluate();
      send_beat(ugcd_pkg::CMD_EVAL, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
   endtask

   // Holds the sender off until every answer is in and the block has settled.
   task automatic drain();
      req.valid <= 0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(int unsigned value);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= value[ugcd_pkg::VC_W-1:0];
      @(posedge clock);
      csr_wr_en <= 0;
      sb.set_count(value & 8'hFF);
   endtask

   task automatic random_graph(int unsigned n);
      int unsigned k;
      int unsigned base;
      int unsigned mode;
      int a;
      int b;
      mode = $urandom_range(0, 9);
      k = $urandom_range(1, (n == 0) ? 1 : n);
      base = $urandom_range(0, 127);
      if (mode < 6) begin
         // A forest, optionally with one extra edge that may close a cycle.
         for (int v = 1; v < k; v++) begin
            if ($urandom_range(0, 5) == 0) continue;
            a = (base + v) % k;
            b = (base + $urandom_range(0, v - 1)) % k;
            if ($urandom_range(0, 1)) add_edge(a, b);
            else add_edge(b, a);
         end
         if (mode >= 3) add_edge($urandom_range(0, k - 1), $urandom_range(0, k - 1));
      end else if (mode < 9) begin
         repeat ($urandom_range(1, 8))
            add_edge($urandom_range(0, k - 1), $urandom_range(0, k - 1));
      end else begin
         repeat ($urandom_range(1, 4))
            add_edge($urandom_range(0, 127), $urandom_range(0, 127));
      end
      evaluate();
   endtask

   initial begin
      int unsigned n;
      cycle_count = 0;
      items_sent = 0;
      quiet = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part, starting at the reset vertex count.
      evaluate();
      add_edge(0, 127);
      add_edge(127, 0);
      evaluate();
      add_edge(5, 5);
      evaluate();
      add_edge(0, 1);
      add_edge(1, 2);
      add_edge(2, 0);
      evaluate();
      write_count(4);
      add_edge(4, 1);
      add_edge(3, 2);
      evaluate();
      write_count(128);
      add_edge(10, 11);
      add_edge(11, 12);
      add_edge(12, 10);
      // Lowering the count after loading hides the cycle from every start.
      write_count(5);
      evaluate();
      write_count(0);
      add_edge(0, 0);
      evaluate();
      write_count(255);
      add_edge(127, 126);
      add_edge(126, 125);
      evaluate();

      // Overfill the edge store.
      write_count(128);
      repeat (EDGE_CAP + 6) add_edge($urandom_range(0, 127), $urandom_range(0, 127));
      evaluate();

      while (items_sent < ITEM_TARGET) begin
         if (items_sent > ITEM_TARGET - 150) quiet = 1;
         case ($urandom_range(0, 7))
            0: n = 128;
            1: n = $urandom_range(129, 255);
            2: n = $urandom_range(0, 2);
            default: n = $urandom_range(3, 14);
         endcase
         write_count(n);
         repeat ($urandom_range(2, 6)) begin
            if (items_sent < ITEM_TARGET) random_graph((n > 128) ? 128 : n);
         end
      end

      drain();
      $display("Sent %0d beats: %0d edges and %0d evaluates, %0d of which found a cycle.",
               items_sent, sb.edges_sent, sb.evals_sent, sb.cycles_found);
      if (sb.fails == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
